>>> hdl/assert_macros.svh
// Assertion macros shared by the congestion window controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> hdl/reno_pkg.sv
// Shared types, constants and helper functions of the congestion window controller.
package reno_pkg;

    localparam int WINDOW_BITS = 16;
    localparam int LOST_W      = 16;
    localparam int CFG_W       = 16;
    localparam int OUT_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int XW          = (WINDOW_BITS > CFG_W) ? WINDOW_BITS : CFG_W;
    localparam int SW          = ((LOST_W + 1) > WINDOW_BITS) ? (LOST_W + 1) : WINDOW_BITS;
    localparam int DIV_CNT_W   = $clog2(LOST_W);

    typedef logic [WINDOW_BITS-1:0] win_t;
    typedef logic [CFG_W-1:0]       cfg_word_t;

    localparam win_t WIN_MAX             = {WINDOW_BITS{1'b1}};
    localparam win_t CWND_RESET          = win_t'(1);
    localparam win_t SSTHRESH_RESET      = win_t'(32);
    localparam cfg_word_t MIN_RESET      = cfg_word_t'(1);
    localparam cfg_word_t MAX_RESET      = cfg_word_t'(65535);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(LOST_W - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_WINDOW      = 3'd0,
        CFG_MAX_WINDOW      = 3'd1,
        CFG_START_THRESHOLD = 3'd2,
        CFG_START_WINDOW    = 3'd3,
        CFG_DECREASE_MODE   = 3'd4
    } reno_cfg_idx_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_evt;
        logic div_start;
        logic div_step;
        logic loss_halve;
        logic loss_sub;
        logic ack_apply;
        logic publish;
    } reno_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic evt_loss;
        logic evt_ack;
        logic slow_start;
        logic sub_mode;
        logic div_last;
        logic res_busy;
    } reno_sts_t;

    // Clamp a window to [min, max], both first saturated to the window range.
    function automatic win_t win_clamp(win_t w, cfg_word_t lo_cfg, cfg_word_t hi_cfg);
        logic [XW-1:0] wmax_x;
        logic [XW-1:0] lo_x;
        logic [XW-1:0] hi_x;
        logic [XW-1:0] v;
        wmax_x = XW'(WIN_MAX);
        lo_x   = XW'(lo_cfg);
        hi_x   = XW'(hi_cfg);
        if (lo_x > wmax_x)
        begin
            lo_x = wmax_x;
        end
        if (hi_x > wmax_x)
        begin
            hi_x = wmax_x;
        end
        v = (XW'(w) < hi_x) ? XW'(w) : hi_x;
        v = (v > lo_x) ? v : lo_x;
        return win_t'(v);
    endfunction

endpackage

>>> hdl/reno_if.sv
// Event and result channel interfaces of the congestion window controller.
interface reno_evt_if
    import reno_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic              ack_valid;
    logic              loss_valid;
    logic [LOST_W-1:0] lost_count;

    modport source (output valid, output ack_valid, output loss_valid, output lost_count,
                    input ready);
    modport sink   (input valid, input ack_valid, input loss_valid, input lost_count,
                    output ready);
endinterface

interface reno_res_if
    import reno_pkg::*;
    ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] window;
    logic [OUT_W-1:0] threshold;
    logic             slow_start;

    modport source (output valid, output window, output threshold, output slow_start,
                    input ready);
    modport sink   (input valid, input window, input threshold, input slow_start,
                    output ready);
endinterface

>>> hdl/reno_ctrl.sv
// Sequencer that steps one event through loss, divide, subtract, ack and publish.
`include "assert_macros.svh"

module reno_ctrl
    import reno_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      evt_valid,
    output logic      evt_ready,
    input  reno_sts_t sts,
    output reno_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOSS,
        S_DIV,
        S_SUB,
        S_ACK,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load_evt = evt_valid;
                if (evt_valid)
                begin
                    state_next = S_LOSS;
                end
            end
            S_LOSS:
            begin
                if (!sts.evt_loss)
                begin
                    state_next = S_ACK;
                end
                else if (sts.slow_start || !sts.sub_mode)
                begin
                    cmd.loss_halve = 1'b1;
                    state_next     = S_ACK;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_SUB;
                end
            end
            S_SUB:
            begin
                cmd.loss_sub = 1'b1;
                state_next   = S_ACK;
            end
            S_ACK:
            begin
                cmd.ack_apply = sts.evt_ack;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (!sts.res_busy)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign evt_ready = (state_reg == S_IDLE);

    `ASSERT_CLK(a_accept_enters_loss, evt_valid && evt_ready |=> state_reg == S_LOSS,
                "accepted request did not enter loss handling")
    `ASSERT_NEVER(a_publish_when_busy, cmd.publish && sts.res_busy,
                  "result published over one not yet taken")
    `ASSERT_CLK(a_div_ends_in_sub, state_reg == S_DIV && sts.div_last |=> state_reg == S_SUB,
                "divide did not hand over to the subtract step")

endmodule

>>> hdl/reno_dp.sv
// Window state, configuration, restoring divider and result register.
`include "assert_macros.svh"

module reno_dp
    import reno_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 ack_valid,
    input  logic                 loss_valid,
    input  logic [LOST_W-1:0]    lost_count,
    input  reno_cmd_t            cmd,
    output reno_sts_t            sts,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic [OUT_W-1:0]     res_window,
    output logic [OUT_W-1:0]     res_threshold,
    output logic                 res_slow_start
);

    // configuration
    cfg_word_t min_window_reg;
    cfg_word_t max_window_reg;
    logic      decrease_mode_reg;

    // window state
    win_t cwnd_reg;
    win_t cwnd_next;
    win_t ssthresh_reg;
    win_t ssthresh_next;
    win_t ack_cnt_reg;
    win_t ack_cnt_next;

    // captured request
    logic              ack_reg;
    logic              loss_reg;
    logic [LOST_W-1:0] lost_reg_hold;

    // divider
    win_t                 rem_reg;
    logic [LOST_W-1:0]    quo_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [WINDOW_BITS:0] trial;
    logic                 trial_ge;

    // result register
    logic             res_valid_reg;
    logic [OUT_W-1:0] res_window_reg;
    logic [OUT_W-1:0] res_threshold_reg;
    logic             res_slow_reg;

    logic          slow;
    win_t          halve_w;
    logic [SW-1:0] dec_x;
    logic [SW-1:0] cw_x;
    win_t          sub_raw;
    win_t          sub_w;
    win_t          inc_w;
    win_t          cnt_inc;

    assign slow     = (cwnd_reg < ssthresh_reg);
    assign halve_w  = win_clamp(cwnd_reg >> 1, min_window_reg, max_window_reg);
    assign dec_x    = SW'(quo_reg) + SW'(1);
    assign cw_x     = SW'(cwnd_reg);
    assign sub_raw  = (dec_x >= cw_x) ? '0 : win_t'(cw_x - dec_x);
    assign sub_w    = win_clamp(sub_raw, min_window_reg, max_window_reg);
    assign inc_w    = (cwnd_reg == WIN_MAX) ? cwnd_reg : cwnd_reg + win_t'(1);
    assign cnt_inc  = (ack_cnt_reg == WIN_MAX) ? ack_cnt_reg : ack_cnt_reg + win_t'(1);
    assign trial    = {rem_reg, quo_reg[LOST_W-1]};
    assign trial_ge = (trial >= {1'b0, cwnd_reg});

    always_comb
    begin
        cwnd_next     = cwnd_reg;
        ssthresh_next = ssthresh_reg;
        ack_cnt_next  = ack_cnt_reg;
        if (cmd.loss_halve)
        begin
            cwnd_next = halve_w;
            if (!slow)
            begin
                ssthresh_next = halve_w;
            end
        end
        if (cmd.loss_sub)
        begin
            cwnd_next     = sub_w;
            ssthresh_next = sub_w;
        end
        if (cmd.ack_apply)
        begin
            if (slow)
            begin
                cwnd_next = win_clamp(inc_w, min_window_reg, max_window_reg);
                // threshold follows the unclamped increment
                if (inc_w >= ssthresh_reg)
                begin
                    ssthresh_next = inc_w;
                end
            end
            else if (cnt_inc >= cwnd_reg)
            begin
                ack_cnt_next = '0;
                cwnd_next    = win_clamp(inc_w, min_window_reg, max_window_reg);
            end
            else
            begin
                ack_cnt_next = cnt_inc;
                cwnd_next    = win_clamp(cwnd_reg, min_window_reg, max_window_reg);
            end
        end
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_START_THRESHOLD:
                begin
                    ssthresh_next = win_t'(cfg_data);
                end
                CFG_START_WINDOW:
                begin
                    cwnd_next    = win_t'(cfg_data);
                    ack_cnt_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_window_reg    <= MIN_RESET;
            max_window_reg    <= MAX_RESET;
            decrease_mode_reg <= 1'b0;
            cwnd_reg          <= CWND_RESET;
            ssthresh_reg      <= SSTHRESH_RESET;
            ack_cnt_reg       <= '0;
            ack_reg           <= 1'b0;
            loss_reg          <= 1'b0;
            res_valid_reg     <= 1'b0;
            div_cnt_reg       <= '0;
        end
        else
        begin
            cwnd_reg     <= cwnd_next;
            ssthresh_reg <= ssthresh_next;
            ack_cnt_reg  <= ack_cnt_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_MIN_WINDOW:    min_window_reg    <= cfg_data;
                    CFG_MAX_WINDOW:    max_window_reg    <= cfg_data;
                    CFG_DECREASE_MODE: decrease_mode_reg <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.load_evt)
            begin
                ack_reg  <= ack_valid;
                loss_reg <= loss_valid;
            end
            if (cmd.div_start)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            end
            if (cmd.publish)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // divider and result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= lost_reg_hold;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? win_t'(trial - {1'b0, cwnd_reg}) : win_t'(trial);
            quo_reg <= {quo_reg[LOST_W-2:0], trial_ge};
        end
        if (cmd.publish)
        begin
            res_window_reg    <= OUT_W'(cwnd_reg);
            res_threshold_reg <= OUT_W'(ssthresh_reg);
            res_slow_reg      <= slow;
        end
    end

    // hold the lost count from acceptance until the divide starts
    always_ff @(posedge clk)
    begin
        if (cmd.load_evt)
        begin
            lost_reg_hold <= lost_count;
        end
    end

    assign sts.evt_loss   = loss_reg;
    assign sts.evt_ack    = ack_reg;
    assign sts.slow_start = slow;
    assign sts.sub_mode   = decrease_mode_reg;
    assign sts.div_last   = (div_cnt_reg == DIV_LAST);
    assign sts.res_busy   = res_valid_reg && !res_ready;

    assign res_valid      = res_valid_reg;
    assign res_window     = res_window_reg;
    assign res_threshold  = res_threshold_reg;
    assign res_slow_start = res_slow_reg;

    `ASSERT_CLK(a_rem_below_divisor,
                cmd.div_step && sts.div_last && cwnd_reg != '0 |=> rem_reg < cwnd_reg,
                "divider remainder not below the window")
    `ASSERT_CLK(a_ack_within_clamps,
                cmd.ack_apply && !cfg_wr_en && min_window_reg <= max_window_reg
                && XW'(max_window_reg) <= XW'(WIN_MAX)
                |=> XW'(cwnd_reg) >= XW'(min_window_reg) && XW'(cwnd_reg) <= XW'(max_window_reg),
                "window outside clamps after ack")

endmodule

>>> hdl/reno_cwnd_controller_core.sv
// Top level of the TCP Reno congestion window controller (AIMD, with an optional additive decrease).
// Each request is captured, handled for loss, then for ack, and published; a loss
//   that takes the additive decrease runs the 16-step restoring divider of lost/cwnd
//   and a subtract step. A new request is taken only once the last one is published.
// Reset (rst_n low, asynchronous): window 1, threshold 32, ack count 0,
//   clamps [1, 65535], halving on loss; no clearing pass, ready at once.
module reno_cwnd_controller_core
    import reno_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    reno_evt_if.sink             evt,
    reno_res_if.source           res,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // Controller and datapath talk only through these two bundles.
    reno_cmd_t cmd;
    reno_sts_t sts;

    // Sequence each request: capture, handle loss (halve, or divide then
    // subtract), handle ack, then publish once the result register is free.
    reno_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt.valid),
        .evt_ready (evt.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Hold the window state and configuration; the result register parts the
    // output side so a new request is taken while a result still waits.
    reno_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .ack_valid      (evt.ack_valid),
        .loss_valid     (evt.loss_valid),
        .lost_count     (evt.lost_count),
        .cmd            (cmd),
        .sts            (sts),
        .res_valid      (res.valid),
        .res_ready      (res.ready),
        .res_window     (res.window),
        .res_threshold  (res.threshold),
        .res_slow_start (res.slow_start)
    );

endmodule

>>> bench/reno_cwnd_controller_core_tb.sv
// Self-checking testbench of the congestion window controller.
module reno_cwnd_controller_core_tb;
    import reno_pkg::*;

    localparam int LIMIT_CYCLES  = 2_000_000;
    localparam int SETTLE_CYCLES = 24;   // longer than a request that takes the divide
    localparam int MAX_SHOWN     = 10;
    localparam int CHUNK_ITEMS   = 50;

    // One published report: window, threshold and slow-start flag.
    typedef struct {
        win_t window;
        win_t threshold;
        logic slow_start;
    } cwnd_report_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    reno_evt_if evt_ch ();
    reno_res_if res_ch ();

    reno_cwnd_controller_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt       (evt_ch),
        .res       (res_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the configuration registers.
    cfg_word_t clamp_lo;
    cfg_word_t clamp_hi;
    cfg_word_t init_threshold;
    cfg_word_t init_window;
    logic      additive_cut;

    // Shadow copy of the window state.
    win_t cwnd_now;
    win_t ssthresh_now;
    win_t ack_tally;

    cwnd_report_t expected_reports[$];

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Window predictor
    // ------------------------------------------------------------------

    // Clamp a window to [min, max]; both bounds saturate to the window range
    // first, and the lower bound wins when the two cross.
    function automatic win_t clamp_cwnd(win_t w);
        win_t lo;
        win_t hi;
        win_t v;
        lo = (clamp_lo > WIN_MAX) ? WIN_MAX : win_t'(clamp_lo);
        hi = (clamp_hi > WIN_MAX) ? WIN_MAX : win_t'(clamp_hi);
        v  = (w < hi) ? w : hi;
        return (v > lo) ? v : lo;
    endfunction

    // Loss: halve in slow start or in halving mode, else cut by lost/cwnd + 1
    // with the subtraction saturating at zero. Outside slow start the
    // threshold follows the new window. The ack tally is left alone.
    task automatic apply_loss(input logic [LOST_W-1:0] lost);
        win_t                 quot;
        logic [WINDOW_BITS:0] cut;
        if (cwnd_now < ssthresh_now)
        begin
            cwnd_now = clamp_cwnd(cwnd_now >> 1);
        end
        else
        begin
            if (additive_cut)
            begin
                // a zero window divides to all ones, as the hardware divider does
                quot     = (cwnd_now == '0) ? WIN_MAX : win_t'(lost / cwnd_now);
                cut      = {1'b0, quot} + 1'b1;
                cwnd_now = clamp_cwnd((cut >= {1'b0, cwnd_now}) ? win_t'(0)
                                                                 : win_t'(cwnd_now - cut));
            end
            else
            begin
                cwnd_now = clamp_cwnd(cwnd_now >> 1);
            end
            ssthresh_now = cwnd_now;
        end
    endtask

    // Ack: slow start grows by one and drags the threshold up when it meets
    // it; congestion avoidance grows by one per full window of acks.
    task automatic apply_ack();
        if (cwnd_now < ssthresh_now)
        begin
            if (cwnd_now != WIN_MAX)
            begin
                cwnd_now = cwnd_now + 1'b1;
            end
            if (cwnd_now >= ssthresh_now)
            begin
                ssthresh_now = cwnd_now;
            end
        end
        else
        begin
            if (ack_tally != WIN_MAX)
            begin
                ack_tally = ack_tally + 1'b1;
            end
            if (ack_tally >= cwnd_now)
            begin
                ack_tally = '0;
                if (cwnd_now != WIN_MAX)
                begin
                    cwnd_now = cwnd_now + 1'b1;
                end
            end
        end
        cwnd_now = clamp_cwnd(cwnd_now);
    endtask

    // Advance the shadow state by one request and return the report it yields.
    task automatic predict_window(input logic ack, input logic loss,
                                  input logic [LOST_W-1:0] lost,
                                  output cwnd_report_t rpt);
        if (loss)
        begin
            apply_loss(lost);
        end
        if (ack)
        begin
            apply_ack();
        end
        rpt.window     = cwnd_now;
        rpt.threshold  = ssthresh_now;
        rpt.slow_start = (cwnd_now < ssthresh_now);
    endtask

    task automatic reset_window_model();
        clamp_lo       = MIN_RESET;
        clamp_hi       = MAX_RESET;
        init_threshold = cfg_word_t'(SSTHRESH_RESET);
        init_window    = cfg_word_t'(CWND_RESET);
        additive_cut   = 1'b0;
        cwnd_now       = CWND_RESET;
        ssthresh_now   = SSTHRESH_RESET;
        ack_tally      = '0;
    endtask

    // ------------------------------------------------------------------
    // Request driver, configuration writes and draining
    // ------------------------------------------------------------------

    // Send one request. Called at a falling edge; returns at a falling edge
    // with valid low. The expectation is queued at the accepting edge.
    task automatic send_event(input logic ack, input logic loss,
                              input logic [LOST_W-1:0] lost);
        cwnd_report_t rpt;
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
        end
        evt_ch.valid      = 1'b1;
        evt_ch.ack_valid  = ack;
        evt_ch.loss_valid = loss;
        evt_ch.lost_count = lost;
        @(posedge clk);
        while (!evt_ch.ready)
        begin
            @(posedge clk);
        end
        predict_window(ack, loss, lost, rpt);
        expected_reports.push_back(rpt);
        @(negedge clk);
        evt_ch.valid = 1'b0;
    endtask

    // Hold the sender until every expected report is back, then let the
    // block settle before anything touches the registers.
    task automatic drain_requests();
        while (expected_reports.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input reno_cfg_idx_t idx, input cfg_word_t value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        case (idx)
            CFG_MIN_WINDOW:      clamp_lo = value;
            CFG_MAX_WINDOW:      clamp_hi = value;
            CFG_START_THRESHOLD:
            begin
                init_threshold = value;
                ssthresh_now   = win_t'(value);
            end
            CFG_START_WINDOW:
            begin
                init_window = value;
                cwnd_now    = win_t'(value);
                ack_tally   = '0;
            end
            CFG_DECREASE_MODE:   additive_cut = value[0];
            default:             ;
        endcase
    endtask

    // Drain, then write every register. Writing the threshold and start
    // window also reloads the live state.
    task automatic configure(input cfg_word_t lo, input cfg_word_t hi,
                             input cfg_word_t thr, input cfg_word_t win,
                             input logic mode);
        drain_requests();
        write_reg(CFG_MIN_WINDOW, lo);
        write_reg(CFG_MAX_WINDOW, hi);
        write_reg(CFG_START_THRESHOLD, thr);
        write_reg(CFG_START_WINDOW, win);
        write_reg(CFG_DECREASE_MODE, cfg_word_t'(mode));
    endtask

    // ------------------------------------------------------------------
    // Receiver and report checker
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic note_error(input string what);
        error_count++;
        if (error_count <= MAX_SHOWN)
        begin
            $display("[%0d] mismatch: %s", cycle_count, what);
        end
    endtask

    // Compare each accepted report with the oldest expectation.
    always @(posedge clk)
    begin
        cwnd_report_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_reports.size() == 0)
            begin
                note_error($sformatf("unexpected report window=%0d threshold=%0d ss=%0b",
                                     res_ch.window, res_ch.threshold, res_ch.slow_start));
            end
            else
            begin
                want = expected_reports.pop_front();
                if (res_ch.window !== want.window || res_ch.threshold !== want.threshold ||
                    res_ch.slow_start !== want.slow_start)
                begin
                    note_error($sformatf(
                        "window exp %0d got %0d, threshold exp %0d got %0d, ss exp %0b got %0b",
                        want.window, res_ch.window, want.threshold, res_ch.threshold,
                        want.slow_start, res_ch.slow_start));
                end
            end
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("reno_cwnd_controller_core_tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset state: empty request, slow-start ack, slow-start loss, both at once.
    task automatic test_reset_state();
        send_event(1'b0, 1'b0, 16'h0000);
        send_event(1'b1, 1'b0, 16'h0000);
        send_event(1'b0, 1'b1, 16'hFFFF);
        send_event(1'b1, 1'b1, 16'h0000);
    endtask

    // Additive cut, saturation at zero, crossed and tight clamps, the
    // threshold ceiling and an ack tally left above a shrunken window.
    task automatic test_loss_and_clamps();
        configure(16'd1, 16'hFFFF, 16'd0, 16'd1000, 1'b1);
        send_event(1'b0, 1'b1, 16'hFFFF);
        send_event(1'b0, 1'b1, 16'h0000);
        send_event(1'b1, 1'b1, 16'h1234);

        // the cut overshoots the window: saturate, then clamp up to the minimum
        configure(16'd1, 16'hFFFF, 16'd0, 16'd10, 1'b1);
        send_event(1'b0, 1'b1, 16'hFFFF);

        // minimum above maximum: the minimum wins
        configure(16'd100, 16'd50, 16'd0, 16'd60, 1'b0);
        send_event(1'b1, 1'b0, 16'h0000);
        send_event(1'b0, 1'b1, 16'h0000);

        configure(16'd1, 16'd1, 16'd32, 16'd1, 1'b0);
        send_event(1'b1, 1'b0, 16'h0000);

        // slow start runs into a threshold at the top of the range
        configure(16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFE, 1'b0);
        send_event(1'b1, 1'b0, 16'h0000);
        send_event(1'b1, 1'b0, 16'h0000);

        // build up the ack tally, halve the window under it, then one more ack
        configure(16'd1, 16'hFFFF, 16'd0, 16'd8, 1'b0);
        repeat (5) send_event(1'b1, 1'b0, 16'h0000);
        send_event(1'b0, 1'b1, 16'h0000);
        send_event(1'b1, 1'b0, 16'h0000);
    endtask

    // Acks at the largest window in congestion avoidance, then a loss there.
    task automatic test_window_ceiling();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(16'd1, 16'hFFFF, 16'd0, 16'hFFFF, 1'b0);
        repeat (8) send_event(1'b1, 1'b0, 16'h0000);
        send_event(1'b1, 1'b1, 16'hFFFF);
    endtask

    // Pick a register setting: mostly small windows so that congestion
    // avoidance wraps often, with the range extremes now and then.
    task automatic random_configure();
        cfg_word_t lo;
        cfg_word_t hi;
        cfg_word_t thr;
        cfg_word_t win;
        case ($urandom_range(9))
            0:       lo = 16'hFFFF;
            1:       lo = cfg_word_t'($urandom_range(65535, 1));
            default: lo = cfg_word_t'($urandom_range(8, 1));
        endcase
        case ($urandom_range(9))
            0:       hi = 16'hFFFF;
            1:       hi = 16'd1;
            2:       hi = cfg_word_t'($urandom_range(65535, 1));
            default: hi = cfg_word_t'($urandom_range(300, 16));
        endcase
        case ($urandom_range(6))
            0:       thr = 16'd0;
            1:       thr = 16'hFFFF;
            2:       thr = cfg_word_t'($urandom_range(65535));
            default: thr = cfg_word_t'($urandom_range(200));
        endcase
        case ($urandom_range(6))
            0:       win = 16'hFFFF;
            1:       win = cfg_word_t'($urandom_range(65535, 1));
            default: win = cfg_word_t'($urandom_range(120, 1));
        endcase
        configure(lo, hi, thr, win, 1'($urandom_range(1)));
    endtask

    // Random requests under the given idling, reconfiguring every chunk.
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int n_items);
        int                  kind;
        int                  span;
        logic                ack;
        logic                loss;
        logic [LOST_W-1:0]   lost;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % CHUNK_ITEMS == 0)
            begin
                random_configure();
            end
            kind = $urandom_range(99);
            ack  = (kind < 55) || (kind >= 70 && kind < 88);
            loss = (kind >= 55 && kind < 88);
            span = (cwnd_now < 16384) ? 4 * int'(cwnd_now) + 3 : 65535;
            case ($urandom_range(8))
                0:       lost = 16'h0000;
                1:       lost = 16'hFFFF;
                2, 3:    lost = LOST_W'($urandom);
                default: lost = LOST_W'($urandom_range(span));
            endcase
            send_event(ack, loss, lost);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        // drive every input from time zero and hold reset
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_index         = CFG_MIN_WINDOW;
        cfg_data          = '0;
        evt_ch.valid      = 1'b0;
        evt_ch.ack_valid  = 1'b0;
        evt_ch.loss_valid = 1'b0;
        evt_ch.lost_count = '0;
        res_ch.ready      = 1'b0;
        reset_window_model();
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_state();
        test_loss_and_clamps();
        test_window_ceiling();
        test_random_traffic(8, 65, 340);
        test_random_traffic(65, 8, 340);
        test_random_traffic(0, 0, 340);

        drain_requests();
        if (error_count == 0 && expected_reports.size() == 0)
        begin
            $display("reno_cwnd_controller_core_tb passed");
        end
        else
        begin
            $display("reno_cwnd_controller_core_tb failed");
        end
        $finish;
    end

endmodule

>>> reno_cwnd_controller_core.f
+incdir+hdl
hdl/reno_pkg.sv
hdl/reno_if.sv
hdl/reno_ctrl.sv
hdl/reno_dp.sv
hdl/reno_cwnd_controller_core.sv
bench/reno_cwnd_controller_core_tb.sv
